>>> rtl/cauchy_weighted_brightness_unit_assert.svh
// Assertion macros for the Cauchy weighted brightness unit.
// Plain text macros only; no dependencies.
`ifndef CAUCHY_WEIGHTED_BRIGHTNESS_UNIT_ASSERT_SVH
`define CAUCHY_WEIGHTED_BRIGHTNESS_UNIT_ASSERT_SVH

// Same-cycle implication under reset.
`define CWB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwb assertion failed");

// Next-cycle implication under reset.
`define CWB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cwb assertion failed");

`endif

>>> rtl/cwb_pkg.sv
// Shared widths, constants and types of the Cauchy weighted brightness unit.
// No dependencies.
package cwb_pkg;

    localparam int IN_W     = 24;
    localparam int OP_W     = 25;
    localparam int PROD_W   = 2 * OP_W;
    localparam int SCALE_W  = 48;
    localparam int PRIOR_W  = 23;
    localparam int SSE_W    = 49;
    localparam int DIV_W    = 51;
    localparam int W_W      = 17;
    localparam int WSUM_W   = 51;
    localparam int WTOT_W   = 27;
    localparam int OUT_W    = 23;
    localparam int CNT_W    = 5;
    localparam int NUM_CHANNELS = 4;
    localparam int MAX_CYCLES   = 1024;

    localparam logic [W_W-1:0]    W_ONE     = 17'h10000;
    localparam logic [CNT_W-1:0]  SQ_LAST   = 5'd3;
    localparam logic [CNT_W-1:0]  WDIV_LAST = 5'd16;
    localparam logic [CNT_W-1:0]  FDIV_LAST = 5'd23;
    localparam logic [OUT_W-1:0]  OUT_MAX   = {OUT_W{1'b1}};
    localparam logic [WTOT_W-1:0] WTOT_MAX  = {WTOT_W{1'b1}};
    localparam logic [WSUM_W-1:0] WSUM_MAX  = {1'b0, {(WSUM_W-1){1'b1}}};
    localparam logic [WSUM_W-1:0] WSUM_MIN  = {1'b1, {(WSUM_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_SQSUM,
        S_DINIT,
        S_WDIV,
        S_WMUL,
        S_ACC,
        S_FINIT,
        S_FDIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic first;
        logic shift_in;
    } t_div_ctl;

endpackage

>>> rtl/cwb_mul.sv
// Shared signed multiplier with registered product.
// Depends on cwb_pkg.
module cwb_mul
    import cwb_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [OP_W-1:0]   i_a,
    input  logic signed [OP_W-1:0]   i_b,
    output logic signed [PROD_W-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule

>>> rtl/cwb_divstep.sv
// One restoring division step, shared by the weight and result divisions.
// Depends on cwb_pkg.
module cwb_divstep
    import cwb_pkg::*;
(
    input  logic [DIV_W-1:0] i_rem,
    input  logic [DIV_W-1:0] i_den,
    input  t_div_ctl         i_ctl,
    output logic [DIV_W-1:0] o_rem,
    output logic             o_ge
);

    logic [DIV_W-1:0] trial;

    always_comb begin
        trial = i_ctl.first ? i_rem : {i_rem[DIV_W-2:0], i_ctl.shift_in};
        o_ge  = (trial >= i_den);
        o_rem = o_ge ? (trial - i_den) : trial;
    end

endmodule

>>> rtl/cauchy_weighted_brightness_unit.sv
// Top level of the Cauchy weighted brightness unit: sequencer and datapath.
// Depends on cwb_pkg, cwb_mul, cwb_divstep and the assertion macro header.
//
//  channel | direction | handshake           | words
//  input   | in        | i_valid / o_ready   | intensities, base, scale, prior, last
//  output  | out       | o_valid / i_ready   | brightness, was_clamped
//
// A new word is taken once the previous one is through its squares, weight division and sums.
// A last word then runs the final division, skipped when the sums are zero or negative and
// cut short on a saturated quotient. The pace is set by the shared compare-subtract unit:
// 17 steps for the weight, 24 for the final quotient, plus four squares on the shared multiplier.
// Reset is synchronous and clears the sequencer, the sums and the output valid.
// A pending result holds the sequencer in its final state; o_ready is high only in idle.
`include "cauchy_weighted_brightness_unit_assert.svh"

module cauchy_weighted_brightness_unit
    import cwb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [IN_W-1:0]    i_intensity_0,
    input  logic signed [IN_W-1:0]    i_intensity_1,
    input  logic signed [IN_W-1:0]    i_intensity_2,
    input  logic signed [IN_W-1:0]    i_intensity_3,
    input  logic [1:0]                i_called_base,
    input  logic [SCALE_W-1:0]        i_scale,
    input  logic [PRIOR_W-1:0]        i_prior_brightness,
    input  logic                      i_last_cycle,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [OUT_W-1:0]          o_brightness,
    output logic                      o_was_clamped
);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic signed [IN_W-1:0] r_x [NUM_CHANNELS];
    logic [1:0]             r_base;
    logic [SCALE_W-1:0]     r_scale;
    logic [PRIOR_W-1:0]     r_prior;
    logic                   r_last;

    logic [SSE_W-1:0]  r_sse, n_sse;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_den, n_den;
    logic [OUT_W-1:0]  r_q, n_q;
    logic [OUT_W-1:0]  r_low, n_low;
    logic [W_W-1:0]    r_w, n_w;
    logic              r_clamp, n_clamp;
    logic signed [WSUM_W-1:0] r_wsum, n_wsum;
    logic [WTOT_W-1:0] r_wtot, n_wtot;

    logic                     r_load;
    logic signed [OP_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    t_div_ctl                 div_ctl;
    logic [DIV_W-1:0]         div_rem;
    logic                     div_ge;

    logic signed [IN_W-1:0]   x_sel, x_b;
    logic signed [OP_W-1:0]   v_sq;
    logic [W_W-1:0]           w_eff;
    logic signed [WSUM_W:0]   wsum_add;
    logic [WTOT_W:0]          wtot_add;
    logic                     accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign r_load  = !o_valid || i_ready;

    cwb_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    cwb_divstep u_div (
        .i_rem (r_rem),
        .i_den (r_den),
        .i_ctl (div_ctl),
        .o_rem (div_rem),
        .o_ge  (div_ge)
    );

    always_comb begin
        x_sel = r_x[r_cnt[1:0]];
        x_b   = r_x[r_base];
        v_sq  = (r_cnt[1:0] == r_base)
              ? ({x_sel[IN_W-1], x_sel} - $signed({2'b00, r_prior}))
              : {x_sel[IN_W-1], x_sel};
        w_eff = (r_den == '0) ? W_ONE : r_q[W_W-1:0];
        wsum_add = {r_wsum[WSUM_W-1], r_wsum}
                 + {{(WSUM_W+1-PROD_W){prod[PROD_W-1]}}, prod};
        wtot_add = {1'b0, r_wtot} + {{(WTOT_W+1-W_W){1'b0}}, r_w};
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_SQ;
            S_SQ:    if (r_cnt == SQ_LAST) n_state = S_SQSUM;
            S_SQSUM: n_state = S_DINIT;
            S_DINIT: n_state = S_WDIV;
            S_WDIV:  if (r_cnt == WDIV_LAST) n_state = S_WMUL;
            S_WMUL:  n_state = S_ACC;
            S_ACC:   n_state = r_last ? S_FINIT : S_IDLE;
            S_FINIT: begin
                if (r_wtot == '0 || r_wsum[WSUM_W-1]) n_state = S_DONE;
                else n_state = S_FDIV;
            end
            S_FDIV: begin
                if ((r_cnt == '0 && div_ge) || r_cnt == FDIV_LAST) n_state = S_DONE;
            end
            S_DONE:  if (r_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls and next values
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        div_ctl = '{first: (r_cnt == '0), shift_in: 1'b0};
        n_cnt   = r_cnt;
        n_sse   = r_sse;
        n_rem   = r_rem;
        n_den   = r_den;
        n_q     = r_q;
        n_low   = r_low;
        n_w     = r_w;
        n_clamp = r_clamp;
        n_wsum  = r_wsum;
        n_wtot  = r_wtot;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                n_sse = '0;
            end
            S_SQ: begin
                mul_a = v_sq;
                mul_b = v_sq;
                if (r_cnt != '0) n_sse = r_sse + prod[SSE_W-1:0];
                n_cnt = r_cnt + 1'b1;
            end
            S_SQSUM: begin
                n_sse = r_sse + prod[SSE_W-1:0];
            end
            S_DINIT: begin
                n_den = DIV_W'({2'b00, r_scale} + {1'b0, r_sse});
                n_rem = DIV_W'(r_scale);
                n_q   = '0;
                n_low = '0;
                n_cnt = '0;
            end
            S_WDIV: begin
                n_rem = div_rem;
                n_q   = {r_q[OUT_W-2:0], div_ge};
                n_cnt = r_cnt + 1'b1;
            end
            S_WMUL: begin
                mul_a = {x_b[IN_W-1], x_b};
                mul_b = $signed({{(OP_W-W_W){1'b0}}, w_eff});
                n_w   = w_eff;
            end
            S_ACC: begin
                if (!wsum_add[WSUM_W] && wsum_add[WSUM_W-1]) n_wsum = WSUM_MAX;
                else if (wsum_add[WSUM_W] && !wsum_add[WSUM_W-1]) n_wsum = WSUM_MIN;
                else n_wsum = wsum_add[WSUM_W-1:0];
                n_wtot = wtot_add[WTOT_W] ? WTOT_MAX : wtot_add[WTOT_W-1:0];
            end
            S_FINIT: begin
                n_q     = '0;
                n_clamp = (r_wtot != '0) && r_wsum[WSUM_W-1];
                n_rem   = DIV_W'(r_wsum[WSUM_W-2:OUT_W]);
                n_low   = r_wsum[OUT_W-1:0];
                n_den   = DIV_W'(r_wtot);
                n_cnt   = '0;
            end
            S_FDIV: begin
                div_ctl.shift_in = r_low[OUT_W-1];
                if (r_cnt != '0) n_low = {r_low[OUT_W-2:0], 1'b0};
                n_rem = div_rem;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '0 && div_ge) n_q = OUT_MAX;
                else n_q = {r_q[OUT_W-2:0], div_ge};
            end
            S_DONE: begin
                if (r_load) begin
                    n_wsum = '0;
                    n_wtot = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_wsum  <= '0;
            r_wtot  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wsum  <= n_wsum;
            r_wtot  <= n_wtot;
            if (r_state == S_DONE && r_load) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x[0]  <= i_intensity_0;
            r_x[1]  <= i_intensity_1;
            r_x[2]  <= i_intensity_2;
            r_x[3]  <= i_intensity_3;
            r_base  <= i_called_base;
            r_scale <= i_scale;
            r_prior <= i_prior_brightness;
            r_last  <= i_last_cycle;
        end
        r_sse   <= n_sse;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_q     <= n_q;
        r_low   <= n_low;
        r_w     <= n_w;
        r_clamp <= n_clamp;
        if (r_state == S_DONE && r_load) begin
            o_brightness  <= r_q;
            o_was_clamped <= r_clamp;
        end
    end

    `CWB_ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, $rose(o_valid), $past(r_state == S_DONE))
    `CWB_ASSERT_IMP(a_weight_range, i_clk, i_rst_n, r_state == S_ACC, r_w <= W_ONE)
    `CWB_ASSERT_IMP(a_clamp_zero, i_clk, i_rst_n, o_valid && o_was_clamped, o_brightness == '0)
    `CWB_ASSERT_NXT(a_sums_cleared, i_clk, i_rst_n, r_state == S_DONE && r_load,
                    r_wsum == '0 && r_wtot == '0)

endmodule
